// File: design/pfr_pkg.sv
// shared types and constants for the page frame replacement unit
package pfr_pkg;
   localparam int NumFramesDefault = 16;
   localparam logic [16:0] PageSizeReset = 17'd4096;
   localparam logic [4:0] FramesReset = 5'd16;
   localparam logic [1:0] PolicyLru = 2'd0;
   localparam logic [1:0] PolicyApprox = 2'd1;
   localparam logic [1:0] PolicySecond = 2'd2;
   localparam logic [1:0] CsrPageSize = 2'd0;
   localparam logic [1:0] CsrFrames = 2'd1;
   localparam logic [1:0] CsrPolicy = 2'd2;

   // what a cell holds
   typedef struct packed {
      logic        valid;
      logic [7:0]  owner;
      logic [31:0] page;
      logic [31:0] use_time;
      logic [31:0] arrival;
      logic        ref_bit;
   } entry_type;

   // write command broadcast to the row
   typedef struct packed {
      logic        hit_wr;
      logic        fill_wr;
      logic        repl_wr;
      logic        stamp_arrival;
      logic [7:0]  owner;
      logic [31:0] page;
      logic [31:0] use_time;
      logic [31:0] arrival;
   } cmd_type;
endpackage

// File: design/pfr_divider.sv
// restoring divider, one quotient bit per cycle
module pfr_divider import pfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = (divisor == '0) ? 17'd1 : divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// File: design/pfr_cell.sv
// one frame slot; during a scan it hands its entry to the neighbor below
module pfr_cell import pfr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      rotate,
   input  logic      clear_ref,
   input  logic      wr_here,
   input  cmd_type   cmd,
   input  entry_type from_next,
   output entry_type entry
);
   entry_type ent_ff, ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (rotate) begin
         ent_in = from_next;
      end else if (clear_ref) begin
         ent_in.ref_bit = 1'b0;
      end else if (wr_here) begin
         if (cmd.hit_wr) begin
            ent_in.use_time = cmd.use_time;
            ent_in.ref_bit  = 1'b1;
         end else begin
            ent_in.valid = 1'b1;
            ent_in.owner = cmd.owner;
            ent_in.page  = cmd.page;
            if (cmd.fill_wr || cmd.stamp_arrival) ent_in.arrival = cmd.arrival;
            if (cmd.fill_wr || !cmd.stamp_arrival) ent_in.use_time = cmd.use_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign entry = ent_ff;
endmodule

// File: design/page_frame_replacement.sv
// page frame replacement unit top level
// One request is taken when start is high and busy is low; its single response
// appears on the rsp_ ports with rsp_valid high for one cycle and cannot be held
// off. A request first divides the address by the page size (one quotient bit per
// cycle), then makes one full rotation of the frame chain, during which cell 0 is
// examined each cycle for hit, empty slot and victim while its entry lies within
// the configured frame count, then applies the result and responds. Configuration may be
// written while busy is low.
module page_frame_replacement import pfr_pkg::*; #(
   parameter int NUM_FRAMES = NumFramesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_process_id,
   input  logic [31:0] req_address,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [3:0]  rsp_frame,
   output logic        rsp_evicted,
   output logic [7:0]  rsp_evicted_owner,
   output logic [31:0] rsp_evicted_page,
   output logic [31:0] rsp_fault_count
);
   localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam logic [2:0] StIdle = 3'd0, StDiv = 3'd1, StScan = 3'd2,
                          StApply = 3'd3, StResp = 3'd4;

   logic [16:0] psize_ff;
   logic [4:0]  nuse_ff;
   logic [1:0]  policy_ff;
   logic [2:0]  st_ff, st_in;
   logic [7:0]  pid_ff;
   logic [31:0] page_ff;
   logic [IW:0] pos_ff, pos_in;   // original index of the entry now in cell 0
   logic [IW:0] n_act;
   logic        div_start, div_done;
   logic [31:0] quotient;
   logic        hit_ff, hit_in, emp_ff, emp_in;
   logic [IW-1:0] hpos_ff, hpos_in, epos_ff, epos_in, best_ff, best_in;
   logic [31:0] low_ff, low_in;
   logic [7:0]  bown_ff, bown_in;
   logic [31:0] bpage_ff, bpage_in;
   logic [NUM_FRAMES-1:0] skip_ff, skip_in;   // frames passed over for their ref bit
   logic [31:0] usec_ff, arrc_ff, faults_ff;
   logic        rotate;
   logic [NUM_FRAMES-1:0] clear_ref;
   logic [NUM_FRAMES-1:0] wr_sel;
   cmd_type     cmd;
   entry_type   ents [NUM_FRAMES];
   entry_type   head;
   logic [31:0] stamp;
   logic        in_range;
   logic        rv_ff, rh_ff, re_ff;
   logic [3:0]  rf_ff;
   logic [7:0]  ro_ff;
   logic [31:0] rp_ff;
   logic [IW-1:0] tgt;
   logic        do_wr;
   logic        evict;

   always_comb begin
      if (nuse_ff == 5'd0) n_act = (IW+1)'(1);
      else if (32'(nuse_ff) > 32'(NUM_FRAMES)) n_act = (IW+1)'(NUM_FRAMES);
      else n_act = (IW+1)'(nuse_ff);
   end

   pfr_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(req_address),
      .divisor(psize_ff), .done(div_done), .quotient(quotient)
   );

   assign busy = (st_ff != StIdle);
   assign div_start = start && !busy;
   assign rotate = (st_ff == StScan);
   assign head = ents[0];
   assign stamp = (policy_ff == PolicySecond) ? head.arrival : head.use_time;
   assign in_range = (pos_ff < n_act);

   // scan bookkeeping, one frame per cycle as the ring rotates
   always_comb begin
      hit_in = hit_ff; emp_in = emp_ff; hpos_in = hpos_ff; epos_in = epos_ff;
      best_in = best_ff; low_in = low_ff; bown_in = bown_ff; bpage_in = bpage_ff;
      skip_in = skip_ff;
      pos_in = pos_ff;
      if (st_ff == StDiv) begin
         hit_in = 1'b0; emp_in = 1'b0; pos_in = '0;
         hpos_in = '0; epos_in = '0; skip_in = '0;
      end else if (st_ff == StScan) begin
         pos_in = pos_ff + 1'b1;
         if (in_range) begin
            if (!hit_ff && head.valid && head.owner == pid_ff && head.page == page_ff) begin
               hit_in = 1'b1; hpos_in = pos_ff[IW-1:0];
            end
            if (!emp_ff && !head.valid) begin
               emp_in = 1'b1; epos_in = pos_ff[IW-1:0];
            end
            if (pos_ff == '0) begin
               best_in = '0; low_in = stamp; bown_in = head.owner; bpage_in = head.page;
            end else if (stamp < low_ff) begin
               if (policy_ff == PolicyLru || !head.ref_bit) begin
                  best_in = pos_ff[IW-1:0]; low_in = stamp;
                  bown_in = head.owner; bpage_in = head.page;
               end else begin
                  skip_in[pos_ff[IW-1:0]] = 1'b1;
               end
            end
         end
      end
   end

   assign do_wr = (st_ff == StApply) &&
                  (hit_ff || emp_ff || policy_ff == PolicyLru ||
                   policy_ff == PolicyApprox || policy_ff == PolicySecond);
   assign evict = do_wr && !hit_ff && !emp_ff;
   assign tgt = hit_ff ? hpos_ff : (emp_ff ? epos_ff : best_ff);

   always_comb begin
      cmd = '0;
      cmd.hit_wr = hit_ff;
      cmd.fill_wr = !hit_ff && emp_ff;
      cmd.repl_wr = !hit_ff && !emp_ff;
      cmd.stamp_arrival = (policy_ff == PolicySecond);
      cmd.owner = pid_ff;
      cmd.page = page_ff;
      cmd.use_time = usec_ff + 32'd1;
      cmd.arrival = arrc_ff + 32'd1;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         wr_sel[i] = do_wr && (tgt == IW'(i));
         // skipped ref bits are only cleared when a victim is really replaced
         clear_ref[i] = evict && skip_ff[i];
      end
   end

   // ring: cell i takes cell i+1; the tail takes the head
   for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
      pfr_cell u_cell (
         .clock(clock), .reset(reset), .rotate(rotate), .clear_ref(clear_ref[g]),
         .wr_here(wr_sel[g]), .cmd(cmd),
         .from_next(ents[(g+1) % NUM_FRAMES]),
         .entry(ents[g])
      );
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         StIdle:  if (start) st_in = StDiv;
         StDiv:   if (div_done) st_in = StScan;
         StScan:  if (pos_ff == (IW+1)'(NUM_FRAMES-1)) st_in = StApply;
         StApply: st_in = StResp;
         StResp:  st_in = StIdle;
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         psize_ff <= PageSizeReset; nuse_ff <= FramesReset; policy_ff <= PolicyLru;
         usec_ff <= '0; arrc_ff <= '0; faults_ff <= '0;
         rv_ff <= 1'b0;
         hit_ff <= 1'b0; emp_ff <= 1'b0; pos_ff <= '0;
      end else begin
         st_ff <= st_in;
         hit_ff <= hit_in; emp_ff <= emp_in; pos_ff <= pos_in;
         rv_ff <= 1'b0;
         if (csr_write && !busy) begin
            unique case (csr_index)
               CsrPageSize: psize_ff <= csr_data;
               CsrFrames:   nuse_ff <= csr_data[4:0];
               CsrPolicy:   policy_ff <= csr_data[1:0];
               default: ;
            endcase
         end
         if (st_ff == StApply) begin
            rv_ff <= 1'b1;
            if (hit_ff || emp_ff) begin
               usec_ff <= usec_ff + 32'd1;
               if (emp_ff && !hit_ff) begin
                  arrc_ff <= arrc_ff + 32'd1;
                  faults_ff <= faults_ff + 32'd1;
               end
            end else if (do_wr) begin
               faults_ff <= faults_ff + 32'd1;
               if (policy_ff == PolicySecond) arrc_ff <= arrc_ff + 32'd1;
               else usec_ff <= usec_ff + 32'd1;
            end
         end
      end
      hpos_ff <= hpos_in; epos_ff <= epos_in; best_ff <= best_in;
      low_ff <= low_in; bown_ff <= bown_in; bpage_ff <= bpage_in;
      skip_ff <= skip_in;
      if (div_start) pid_ff <= req_process_id;
      if (div_done) page_ff <= quotient;
      if (st_ff == StApply) begin
         rh_ff <= hit_ff;
         rf_ff <= do_wr ? 4'(tgt) : 4'd0;
         re_ff <= do_wr && !hit_ff && !emp_ff;
         ro_ff <= (do_wr && !hit_ff && !emp_ff) ? bown_ff : 8'd0;
         rp_ff <= (do_wr && !hit_ff && !emp_ff) ? bpage_ff : 32'd0;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_hit = rh_ff;
   assign rsp_frame = rf_ff;
   assign rsp_evicted = re_ff;
   assign rsp_evicted_owner = ro_ff;
   assign rsp_evicted_page = rp_ff;
   assign rsp_fault_count = faults_ff;
endmodule
